// ===== design/tbc_pkg.sv =====
package tbc_pkg;

    localparam int WORD_WIDTH_DEF  = 32;
    localparam int BLOCK_WIDTH_DEF = 16;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_FREQ = 2'd1;
    localparam logic [1:0] ERR_BLK  = 2'd2;

    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t STEP_IDLE      = 5'd0;
    localparam pc_t STEP_CHECK     = 5'd1;
    localparam pc_t STEP_WAVE_GO   = 5'd2;
    localparam pc_t STEP_WAVE_WAIT = 5'd3;
    localparam pc_t STEP_WAVE_SET  = 5'd4;
    localparam pc_t STEP_GCD_TEST  = 5'd5;
    localparam pc_t STEP_GCD_GO    = 5'd6;
    localparam pc_t STEP_GCD_WAIT  = 5'd7;
    localparam pc_t STEP_GCD_SWAP  = 5'd8;
    localparam pc_t STEP_RED_GO    = 5'd9;
    localparam pc_t STEP_RED_WAIT  = 5'd10;
    localparam pc_t STEP_MUL_SET   = 5'd11;
    localparam pc_t STEP_MUL_LOOP  = 5'd12;
    localparam pc_t STEP_BLK_GO    = 5'd13;
    localparam pc_t STEP_BLK_WAIT  = 5'd14;
    localparam pc_t STEP_BLK_SET   = 5'd15;
    localparam pc_t STEP_UPDATE    = 5'd16;
    localparam pc_t STEP_EMIT      = 5'd17;
    localparam pc_t STEP_DONE      = 5'd18;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_DIV_WAVE,
        OP_SET_WAVE,
        OP_DIV_XY,
        OP_STEP_EUCLID,
        OP_DIV_G,
        OP_SET_MUL,
        OP_MUL,
        OP_DIV_BLK,
        OP_SET_BLOCKS,
        OP_UPDATE,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_START,
        COND_ERR,
        COND_DIV_BUSY,
        COND_Y_ZERO,
        COND_MUL_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } uword_t;

    typedef struct packed {
        op_t  op;
        logic idle;
    } ctrl_t;

    typedef struct packed {
        logic start;
        logic err;
        logic div_busy;
        logic y_zero;
        logic mul_more;
        logic out_busy;
    } stat_t;

    function automatic uword_t ucode(pc_t pc);
        uword_t w;
        unique case (pc)
            STEP_IDLE:      w = '{OP_NOP,         COND_NO_START, STEP_IDLE};
            STEP_CHECK:     w = '{OP_NOP,         COND_ERR,      STEP_EMIT};
            STEP_WAVE_GO:   w = '{OP_DIV_WAVE,    COND_NONE,     STEP_IDLE};
            STEP_WAVE_WAIT: w = '{OP_NOP,         COND_DIV_BUSY, STEP_WAVE_WAIT};
            STEP_WAVE_SET:  w = '{OP_SET_WAVE,    COND_NONE,     STEP_IDLE};
            STEP_GCD_TEST:  w = '{OP_NOP,         COND_Y_ZERO,   STEP_RED_GO};
            STEP_GCD_GO:    w = '{OP_DIV_XY,      COND_NONE,     STEP_IDLE};
            STEP_GCD_WAIT:  w = '{OP_NOP,         COND_DIV_BUSY, STEP_GCD_WAIT};
            STEP_GCD_SWAP:  w = '{OP_STEP_EUCLID, COND_ALWAYS,   STEP_GCD_TEST};
            STEP_RED_GO:    w = '{OP_DIV_G,       COND_NONE,     STEP_IDLE};
            STEP_RED_WAIT:  w = '{OP_NOP,         COND_DIV_BUSY, STEP_RED_WAIT};
            STEP_MUL_SET:   w = '{OP_SET_MUL,     COND_NONE,     STEP_IDLE};
            STEP_MUL_LOOP:  w = '{OP_MUL,         COND_MUL_MORE, STEP_MUL_LOOP};
            STEP_BLK_GO:    w = '{OP_DIV_BLK,     COND_NONE,     STEP_IDLE};
            STEP_BLK_WAIT:  w = '{OP_NOP,         COND_DIV_BUSY, STEP_BLK_WAIT};
            STEP_BLK_SET:   w = '{OP_SET_BLOCKS,  COND_NONE,     STEP_IDLE};
            STEP_UPDATE:    w = '{OP_UPDATE,      COND_NONE,     STEP_IDLE};
            STEP_EMIT:      w = '{OP_EMIT,        COND_OUT_BUSY, STEP_EMIT};
            STEP_DONE:      w = '{OP_NOP,         COND_ALWAYS,   STEP_IDLE};
            default:        w = '{OP_NOP,         COND_ALWAYS,   STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== design/tbc_chan_if.sv =====
interface tbc_in_if #(
    parameter int WORD_WIDTH  = tbc_pkg::WORD_WIDTH_DEF,
    parameter int BLOCK_WIDTH = tbc_pkg::BLOCK_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [WORD_WIDTH-1:0]  freq_hz;
    logic [WORD_WIDTH-1:0]  samp_rate;
    logic [BLOCK_WIDTH-1:0] blk_size;

    modport source (output valid, freq_hz, samp_rate, blk_size, input ready);
    modport sink (input valid, freq_hz, samp_rate, blk_size, output ready);
endinterface

interface tbc_out_if #(
    parameter int WORD_WIDTH = tbc_pkg::WORD_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic [WORD_WIDTH-1:0] wave_len;
    logic [WORD_WIDTH-1:0] total_count;
    logic [WORD_WIDTH-1:0] block_count;
    logic                  new_max;
    logic [1:0]            err_code;

    modport source (output valid, wave_len, total_count, block_count, new_max, err_code,
                    input ready);
    modport sink (input valid, wave_len, total_count, block_count, new_max, err_code,
                  output ready);
endinterface

// ===== design/tbc_div.sv =====
module tbc_div #(
    parameter int WIDTH = tbc_pkg::WORD_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             busy,
    output logic [WIDTH-1:0] quot,
    output logic [WIDTH-1:0] rem
);
    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [WIDTH-1:0] q_reg;
    logic [WIDTH-1:0] r_reg;
    logic [WIDTH-1:0] d_reg;
    logic [WIDTH:0]   r_shift;
    logic [WIDTH:0]   diff;

    assign r_shift = {r_reg, q_reg[WIDTH-1]};
    assign diff    = r_shift - {1'b0, d_reg};
    assign busy    = (cnt_reg != '0);
    assign quot    = q_reg;
    assign rem     = r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(WIDTH);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy)
        begin
            if (!diff[WIDTH])
            begin
                r_reg <= diff[WIDTH-1:0];
                q_reg <= {q_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r_shift[WIDTH-1:0];
                q_reg <= {q_reg[WIDTH-2:0], 1'b0};
            end
        end
    end
endmodule

// ===== design/tbc_seq.sv =====
module tbc_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  tbc_pkg::stat_t  stat,
    output tbc_pkg::ctrl_t  ctrl
);
    tbc_pkg::pc_t    pc_reg;
    tbc_pkg::pc_t    pc_next;
    tbc_pkg::uword_t word;
    logic            jump;

    assign word      = tbc_pkg::ucode(pc_reg);
    assign ctrl.op   = word.op;
    assign ctrl.idle = (pc_reg == tbc_pkg::STEP_IDLE);

    always_comb
    begin
        unique case (word.cond)
            tbc_pkg::COND_NONE:     jump = 1'b0;
            tbc_pkg::COND_ALWAYS:   jump = 1'b1;
            tbc_pkg::COND_NO_START: jump = !stat.start;
            tbc_pkg::COND_ERR:      jump = stat.err;
            tbc_pkg::COND_DIV_BUSY: jump = stat.div_busy;
            tbc_pkg::COND_Y_ZERO:   jump = stat.y_zero;
            tbc_pkg::COND_MUL_MORE: jump = stat.mul_more;
            tbc_pkg::COND_OUT_BUSY: jump = stat.out_busy;
            default:                jump = 1'b1;
        endcase
        pc_next = jump ? word.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= tbc_pkg::STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= tbc_pkg::STEP_DONE)
        else $error("step counter out of program");

    a_wait_on_div: assert property (@(posedge clk) disable iff (!rst_n)
        (word.cond == tbc_pkg::COND_DIV_BUSY && stat.div_busy) |=> $stable(pc_reg))
        else $error("sequencer left a divide wait early");

    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.idle && stat.start) |=> (pc_reg == tbc_pkg::STEP_CHECK))
        else $error("accepted word did not start the program");
endmodule

// ===== design/tone_block_count_lcm.sv =====
// channel  dir  fields
// in_ch    in   freq_hz, samp_rate, blk_size
// out_ch   out  wave_len, total_count, block_count, new_max, err_code
//
// one word at a time; every divide goes through the shared one-bit-per-cycle divider
// (DW = larger of WORD_WIDTH and BLOCK_WIDTH), and the euclid loop runs one divide per
// iteration; a zero freq_hz or blk_size goes straight to the error output; the
// multiply runs one bit of blk_size per cycle
// rst_n clears the sequencer, the running maximum and the output valid
// in_ch.ready is high only while the sequencer sits at its idle step
// a held result waits in the output register while the next word is taken
module tone_block_count_lcm #(
    parameter int WORD_WIDTH  = tbc_pkg::WORD_WIDTH_DEF,
    parameter int BLOCK_WIDTH = tbc_pkg::BLOCK_WIDTH_DEF
) (
    input logic        clk,
    input logic        rst_n,
    tbc_in_if.sink     in_ch,
    tbc_out_if.source  out_ch
);
    localparam int DW = (WORD_WIDTH > BLOCK_WIDTH) ? WORD_WIDTH : BLOCK_WIDTH;

    tbc_pkg::ctrl_t ctrl;
    tbc_pkg::stat_t stat;

    logic                   in_fire;
    logic                   out_busy;
    logic                   emit_fire;
    logic                   total_gt;

    logic                   div_start;
    logic                   div_busy;
    logic [DW-1:0]          div_num;
    logic [DW-1:0]          div_den;
    logic [DW-1:0]          div_quot;
    logic [DW-1:0]          div_rem;

    logic [WORD_WIDTH-1:0]  freq_reg;
    logic [WORD_WIDTH-1:0]  rate_reg;
    logic [BLOCK_WIDTH-1:0] blk_reg;
    logic [1:0]             err_reg;
    logic [WORD_WIDTH-1:0]  wave_reg;
    logic [DW-1:0]          x_reg;
    logic [BLOCK_WIDTH-1:0] y_reg;
    logic [WORD_WIDTH-1:0]  mcand_reg;
    logic [BLOCK_WIDTH-1:0] mb_reg;
    logic [WORD_WIDTH-1:0]  total_reg;
    logic [WORD_WIDTH-1:0]  blocks_reg;
    logic                   flag_reg;

    logic [WORD_WIDTH-1:0]  best_total_reg;
    logic [WORD_WIDTH-1:0]  best_blocks_reg;
    logic [WORD_WIDTH-1:0]  best_rate_reg;

    logic                   out_valid_reg;
    logic [WORD_WIDTH-1:0]  out_wave_reg;
    logic [WORD_WIDTH-1:0]  out_total_reg;
    logic [WORD_WIDTH-1:0]  out_blocks_reg;
    logic                   out_max_reg;
    logic [1:0]             out_err_reg;

    assign in_ch.ready = ctrl.idle;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_busy    = out_valid_reg && !out_ch.ready;
    assign emit_fire   = (ctrl.op == tbc_pkg::OP_EMIT) && !out_busy;
    assign total_gt    = total_reg > best_total_reg;

    assign stat.start    = in_fire;
    assign stat.err      = (err_reg != tbc_pkg::ERR_OK);
    assign stat.div_busy = div_busy;
    assign stat.y_zero   = (y_reg == '0);
    assign stat.mul_more = (mb_reg[BLOCK_WIDTH-1:1] != '0);
    assign stat.out_busy = out_busy;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.wave_len    = out_wave_reg;
    assign out_ch.total_count = out_total_reg;
    assign out_ch.block_count = out_blocks_reg;
    assign out_ch.new_max     = out_max_reg;
    assign out_ch.err_code    = out_err_reg;

    tbc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    always_comb
    begin
        div_start = 1'b1;
        unique case (ctrl.op)
            tbc_pkg::OP_DIV_WAVE:
            begin
                div_num = DW'(rate_reg);
                div_den = DW'(freq_reg);
            end
            tbc_pkg::OP_DIV_XY:
            begin
                div_num = x_reg;
                div_den = DW'(y_reg);
            end
            tbc_pkg::OP_DIV_G:
            begin
                div_num = DW'(wave_reg);
                div_den = x_reg;
            end
            tbc_pkg::OP_DIV_BLK:
            begin
                div_num = DW'(total_reg);
                div_den = DW'(blk_reg);
            end
            default:
            begin
                div_start = 1'b0;
                div_num   = '0;
                div_den   = '0;
            end
        endcase
    end

    tbc_div #(
        .WIDTH (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            freq_reg <= in_ch.freq_hz;
            rate_reg <= in_ch.samp_rate;
            blk_reg  <= in_ch.blk_size;
            if (in_ch.freq_hz == '0)
            begin
                err_reg <= tbc_pkg::ERR_FREQ;
            end
            else if (in_ch.blk_size == '0)
            begin
                err_reg <= tbc_pkg::ERR_BLK;
            end
            else
            begin
                err_reg <= tbc_pkg::ERR_OK;
            end
        end
        unique case (ctrl.op)
            tbc_pkg::OP_SET_WAVE:
            begin
                wave_reg <= WORD_WIDTH'(div_quot);
                x_reg    <= div_quot;
                y_reg    <= blk_reg;
            end
            tbc_pkg::OP_STEP_EUCLID:
            begin
                x_reg <= DW'(y_reg);
                y_reg <= BLOCK_WIDTH'(div_rem);
            end
            tbc_pkg::OP_SET_MUL:
            begin
                mcand_reg <= WORD_WIDTH'(div_quot);
                total_reg <= '0;
                mb_reg    <= blk_reg;
            end
            tbc_pkg::OP_MUL:
            begin
                if (mb_reg[0])
                begin
                    total_reg <= total_reg + mcand_reg;
                end
                mcand_reg <= {mcand_reg[WORD_WIDTH-2:0], 1'b0};
                mb_reg    <= mb_reg >> 1;
            end
            tbc_pkg::OP_SET_BLOCKS:
            begin
                blocks_reg <= WORD_WIDTH'(div_quot);
            end
            tbc_pkg::OP_UPDATE:
            begin
                flag_reg <= total_gt;
            end
            tbc_pkg::OP_EMIT:
            begin
                if (!out_busy)
                begin
                    out_err_reg <= err_reg;
                    if (err_reg != tbc_pkg::ERR_OK)
                    begin
                        out_wave_reg   <= '0;
                        out_total_reg  <= '0;
                        out_blocks_reg <= '0;
                        out_max_reg    <= 1'b0;
                    end
                    else
                    begin
                        out_wave_reg   <= wave_reg;
                        out_total_reg  <= total_reg;
                        out_blocks_reg <= blocks_reg;
                        out_max_reg    <= flag_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            best_total_reg  <= '0;
            best_blocks_reg <= '0;
            best_rate_reg   <= '0;
        end
        else
        begin
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((ctrl.op == tbc_pkg::OP_UPDATE) && total_gt)
            begin
                best_total_reg  <= total_reg;
                best_blocks_reg <= blocks_reg;
                best_rate_reg   <= rate_reg;
            end
        end
    end

    // best_blocks and best_rate are kept as state alongside the maximum
    a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (best_total_reg >= $past(best_total_reg)))
        else $error("running maximum decreased");

    a_best_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        ((ctrl.op == tbc_pkg::OP_UPDATE) && total_gt) |=>
            (best_total_reg == $past(total_reg)) && (best_blocks_reg == $past(blocks_reg))
            && (best_rate_reg == $past(rate_reg)))
        else $error("new maximum not stored");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_err_reg != tbc_pkg::ERR_OK)) |->
            (out_total_reg == '0) && (out_wave_reg == '0) && !out_max_reg)
        else $error("error word carries nonzero results");

    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.idle |-> !div_busy)
        else $error("divider busy while idle");
endmodule
